### rtl/core/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes and types of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // Map geometry
    localparam int MAX_PAGE_COUNT = 262144;
    localparam int WORD_BITS      = 32;
    localparam int MAP_WORDS      = MAX_PAGE_COUNT / WORD_BITS;
    localparam int SUM_WORDS      = MAP_WORDS / WORD_BITS;
    localparam int TOP_BITS       = SUM_WORDS / WORD_BITS;
    localparam int BIT_W          = $clog2(WORD_BITS);
    localparam int MAP_AW         = $clog2(MAP_WORDS);
    localparam int SUM_AW         = $clog2(SUM_WORDS);
    localparam int TOP_W          = $clog2(TOP_BITS);
    localparam int PAGE_W         = $clog2(MAX_PAGE_COUNT);

    // Field widths
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 64;
    localparam int BASE_W     = 52;
    localparam int COUNT_W    = 19;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BASE_W;

    // Request kinds
    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

    // Result status
    localparam logic [STATUS_W-1:0] STS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NO_PAGE     = 2'd1;
    localparam logic [STATUS_W-1:0] STS_BAD_ADDR    = 2'd2;
    localparam logic [STATUS_W-1:0] STS_DOUBLE_FREE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES = 1'd1;

    // Access to the map and summary memories
    typedef struct packed {
        logic                 map_re;
        logic                 map_we;
        logic [MAP_AW-1:0]    map_addr;
        logic [WORD_BITS-1:0] map_wdata;
        logic                 sum_re;
        logic                 sum_we;
        logic [SUM_AW-1:0]    sum_addr;
        logic [WORD_BITS-1:0] sum_wdata;
    } t_store_req;

endpackage
`default_nettype wire

### rtl/core/bpa_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_if
// Request and response channels of the bitmap page allocator.
// ----------------------------------------------------------------------------
interface bpa_req_if
    import bpa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;

    modport source (output valid, func, addr, input ready);
    modport sink   (input valid, func, addr, output ready);
endinterface

interface bpa_rsp_if
    import bpa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   page_addr;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  used_count;

    modport source (output valid, page_addr, status, free_count, used_count, input ready);
    modport sink   (input valid, page_addr, status, free_count, used_count, output ready);
endinterface
`default_nettype wire

### rtl/core/bpa_ffs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ffs
// Find-first-set over one map word, shared by every level of the search.
// ----------------------------------------------------------------------------
module bpa_ffs
    import bpa_pkg::*;
(
    input  wire logic [WORD_BITS-1:0] i_word,
    output logic                      o_found,
    output logic [BIT_W-1:0]          o_idx
);

    always_comb begin
        o_idx = '0;
        // lowest set bit wins
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (i_word[k]) begin
                o_idx = BIT_W'(k);
            end
        end
        o_found = |i_word;
    end

endmodule
`default_nettype wire

### rtl/core/bpa_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_store
// Free map memory (one bit per page) and the summary memory that marks
// map words holding at least one free page.
// ----------------------------------------------------------------------------
module bpa_store
    import bpa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire t_store_req           i_req,
    output logic [WORD_BITS-1:0]      o_map_rdata,
    output logic [WORD_BITS-1:0]      o_sum_rdata
);

    logic [WORD_BITS-1:0] r_map [MAP_WORDS];
    logic [WORD_BITS-1:0] r_sum [SUM_WORDS];

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.map_we) begin
            r_map[i_req.map_addr] <= i_req.map_wdata;
        end
        if (i_req.map_re) begin
            o_map_rdata <= r_map[i_req.map_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.sum_we) begin
            r_sum[i_req.sum_addr] <= i_req.sum_wdata;
        end
        if (i_req.sum_re) begin
            o_sum_rdata <= r_sum[i_req.sum_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/core/bitmap_page_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit
// First-fit physical page allocator over a one-bit-per-page free map.
// ----------------------------------------------------------------------------
// Requests arrive on i_req (func, addr) and each produces one item on o_rsp
// (page_addr, status, free_count, used_count). i_req.ready is high only when
// the sequencer is idle; one request is worked on at a time.
// Allocate walks a three-level summary (top bits and summary words in flops,
// a summary memory) down to the free map through one shared find-first-set
// unit, in the states S_DECODE, S_L1, S_SUM, S_MAP and S_RESP; the response
// register is loaded in S_RESP, after which the next request can be accepted.
// Free passes S_DECODE, S_FREE and S_RESP, an unused request kind S_DECODE and
// S_RESP. Clear sweeps the whole map, one word per cycle, then responds.
// After reset the same sweep runs before the first request is accepted;
// configuration writes on i_cfg_* are taken at any time and are expected
// only while no request is in flight.
// A finished response waits in the output register while o_rsp is stalled;
// the next request is accepted meanwhile, and its response is held back
// until the register is free.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit
    import bpa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    bpa_req_if.sink                    i_req,
    bpa_rsp_if.source                  o_rsp
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_L1, S_SUM, S_MAP, S_FREE, S_RESP
    } t_state;

    localparam logic [COUNT_W-1:0] LIMIT_CAP = COUNT_W'(MAX_PAGE_COUNT);
    localparam logic [MAP_AW-1:0]  CLR_LAST  = MAP_AW'(MAP_WORDS - 1);

    // configuration
    logic [BASE_W-1:0]  r_base;
    logic [COUNT_W-1:0] r_total;

    // sequencer state
    t_state               r_state, n_state;
    logic [MAP_AW-1:0]    r_clr_cnt, n_clr_cnt;
    logic                 r_clr_req, n_clr_req;
    logic [FUNC_W-1:0]    r_func, n_func;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [TOP_W-1:0]     r_i2, n_i2;
    logic [BIT_W-1:0]     r_i1, n_i1;
    logic [BIT_W-1:0]     r_i0, n_i0;
    logic [PAGE_W-1:0]    r_page, n_page;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic                 r_alloc_ok, n_alloc_ok;
    logic [COUNT_W-1:0]   r_used, n_used;
    logic [TOP_BITS-1:0]  r_l2, n_l2;
    logic [WORD_BITS-1:0] r_l1 [TOP_BITS];
    logic [WORD_BITS-1:0] n_l1 [TOP_BITS];

    // response register
    logic                r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]   r_page_addr, n_page_addr;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [COUNT_W-1:0]  r_free_cnt, n_free_cnt;
    logic [COUNT_W-1:0]  r_used_cnt, n_used_cnt;

    // datapath
    t_store_req           st_req;
    logic [WORD_BITS-1:0] map_rdata;
    logic [WORD_BITS-1:0] sum_rdata;
    logic [WORD_BITS-1:0] ffs_word;
    logic                 ffs_found;
    logic [BIT_W-1:0]     ffs_idx;
    logic [COUNT_W-1:0]   limit;
    logic [ADDR_W-1:0]    region_addr;
    logic [ADDR_W-1:0]    diff;
    logic                 free_bad;
    logic [PAGE_W-1:0]    alloc_page;
    logic [WORD_BITS-1:0] map_clr;
    logic [WORD_BITS-1:0] sum_clr;
    logic [WORD_BITS-1:0] l1_clr;

    bpa_store u_store (
        .i_clk       (i_clk),
        .i_req       (st_req),
        .o_map_rdata (map_rdata),
        .o_sum_rdata (sum_rdata)
    );

    bpa_ffs u_ffs (
        .i_word  (ffs_word),
        .o_found (ffs_found),
        .o_idx   (ffs_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_W'(1);
            r_total <= LIMIT_CAP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_PAGE: begin
                    r_base <= i_cfg_data;
                end
                CFG_TOTAL_PAGES: begin
                    r_total <= i_cfg_data[COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign limit       = (r_total > LIMIT_CAP) ? LIMIT_CAP : r_total;
    assign region_addr = {r_base, {PAGE_SHIFT{1'b0}}};
    assign diff        = r_addr - region_addr;
    assign free_bad  = (r_addr == '0) || (r_addr[PAGE_SHIFT-1:0] != '0) ||
                       (diff[ADDR_W-1:PAGE_SHIFT+COUNT_W] != '0) ||
                       (diff[PAGE_SHIFT +: COUNT_W] >= limit);
    assign alloc_page = {r_i2, r_i1, r_i0, ffs_idx};
    assign map_clr    = map_rdata & ~(WORD_BITS'(1) << ffs_idx);
    assign sum_clr    = sum_rdata & ~(WORD_BITS'(1) << r_i0);
    assign l1_clr     = r_l1[r_i2] & ~(WORD_BITS'(1) << r_i1);

    // one find-first-set serves every level of the search
    always_comb begin
        case (r_state)
            S_DECODE: ffs_word = WORD_BITS'(r_l2);
            S_L1:     ffs_word = r_l1[r_i2];
            S_SUM:    ffs_word = sum_rdata;
            S_MAP:    ffs_word = map_rdata;
            default:  ffs_word = '0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_clr_req    = r_clr_req;
        n_func       = r_func;
        n_addr       = r_addr;
        n_i2         = r_i2;
        n_i1         = r_i1;
        n_i0         = r_i0;
        n_page       = r_page;
        n_status     = r_status;
        n_alloc_ok   = r_alloc_ok;
        n_used       = r_used;
        n_l2         = r_l2;
        n_l1         = r_l1;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_page_addr  = r_page_addr;
        n_out_status = r_out_status;
        n_free_cnt   = r_free_cnt;
        n_used_cnt   = r_used_cnt;
        st_req       = '0;

        case (r_state)
            S_CLEAR: begin
                st_req.map_we    = 1'b1;
                st_req.map_addr  = r_clr_cnt;
                st_req.map_wdata = '1;
                st_req.sum_we    = (r_clr_cnt[MAP_AW-1:SUM_AW] == '0);
                st_req.sum_addr  = r_clr_cnt[SUM_AW-1:0];
                st_req.sum_wdata = '1;
                n_clr_cnt        = r_clr_cnt + MAP_AW'(1);
                if (r_clr_cnt == CLR_LAST) begin
                    n_state   = r_clr_req ? S_RESP : S_IDLE;
                    n_clr_req = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func     = i_req.func;
                    n_addr     = i_req.addr;
                    n_status   = STS_OK;
                    n_alloc_ok = 1'b0;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_func)
                    FN_ALLOC: begin
                        if (!ffs_found) begin
                            n_status = STS_NO_PAGE;
                            n_state  = S_RESP;
                        end else begin
                            n_i2    = ffs_idx[TOP_W-1:0];
                            n_state = S_L1;
                        end
                    end
                    FN_FREE: begin
                        if (free_bad) begin
                            n_status = STS_BAD_ADDR;
                            n_state  = S_RESP;
                        end else begin
                            n_page          = diff[PAGE_SHIFT +: PAGE_W];
                            st_req.map_re   = 1'b1;
                            st_req.map_addr = diff[PAGE_SHIFT+BIT_W +: MAP_AW];
                            st_req.sum_re   = 1'b1;
                            st_req.sum_addr = diff[PAGE_SHIFT+2*BIT_W +: SUM_AW];
                            n_state         = S_FREE;
                        end
                    end
                    FN_CLEAR: begin
                        n_used    = '0;
                        n_l2      = '1;
                        for (int k = 0; k < TOP_BITS; k++) begin
                            n_l1[k] = '1;
                        end
                        n_clr_cnt = '0;
                        n_clr_req = 1'b1;
                        n_state   = S_CLEAR;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_L1: begin
                n_i1            = ffs_idx;
                st_req.sum_re   = 1'b1;
                st_req.sum_addr = {r_i2, ffs_idx};
                n_state         = S_SUM;
            end
            S_SUM: begin
                n_i0            = ffs_idx;
                st_req.map_re   = 1'b1;
                st_req.map_addr = {r_i2, r_i1, ffs_idx};
                n_state         = S_MAP;
            end
            S_MAP: begin
                // lowest free page overall; at or past the limit means none below it
                if ({1'b0, alloc_page} >= limit) begin
                    n_status = STS_NO_PAGE;
                end else begin
                    st_req.map_we    = 1'b1;
                    st_req.map_addr  = {r_i2, r_i1, r_i0};
                    st_req.map_wdata = map_clr;
                    if (map_clr == '0) begin
                        st_req.sum_we    = 1'b1;
                        st_req.sum_addr  = {r_i2, r_i1};
                        st_req.sum_wdata = sum_clr;
                        if (sum_clr == '0) begin
                            n_l1[r_i2] = l1_clr;
                            if (l1_clr == '0) begin
                                n_l2[r_i2] = 1'b0;
                            end
                        end
                    end
                    if (r_used != '1) begin
                        n_used = r_used + COUNT_W'(1);
                    end
                    n_page     = alloc_page;
                    n_alloc_ok = 1'b1;
                end
                n_state = S_RESP;
            end
            S_FREE: begin
                if (map_rdata[r_page[BIT_W-1:0]]) begin
                    n_status = STS_DOUBLE_FREE;
                end else begin
                    st_req.map_we    = 1'b1;
                    st_req.map_addr  = r_page[PAGE_W-1:BIT_W];
                    st_req.map_wdata = map_rdata | (WORD_BITS'(1) << r_page[BIT_W-1:0]);
                    st_req.sum_we    = 1'b1;
                    st_req.sum_addr  = r_page[PAGE_W-1:2*BIT_W];
                    st_req.sum_wdata = sum_rdata |
                                       (WORD_BITS'(1) << r_page[BIT_W +: BIT_W]);
                    n_l1[r_page[PAGE_W-1 -: TOP_W]] = r_l1[r_page[PAGE_W-1 -: TOP_W]] |
                        (WORD_BITS'(1) << r_page[2*BIT_W +: BIT_W]);
                    n_l2[r_page[PAGE_W-1 -: TOP_W]] = 1'b1;
                    if (r_used != '0) begin
                        n_used = r_used - COUNT_W'(1);
                    end
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                // hold until the response register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_page_addr  = r_alloc_ok ?
                                   region_addr + {{(ADDR_W-PAGE_W-PAGE_SHIFT){1'b0}},
                                                  r_page, {PAGE_SHIFT{1'b0}}} : '0;
                    n_out_status = r_status;
                    n_free_cnt   = (r_total > r_used) ? r_total - r_used : '0;
                    n_used_cnt   = r_used;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_clr_req   <= 1'b0;
            r_used      <= '0;
            r_l2        <= '1;
            for (int k = 0; k < TOP_BITS; k++) begin
                r_l1[k] <= '1;
            end
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_clr_req   <= n_clr_req;
            r_used      <= n_used;
            r_l2        <= n_l2;
            r_l1        <= n_l1;
            r_out_valid <= n_out_valid;
        end
        r_func       <= n_func;
        r_addr       <= n_addr;
        r_i2         <= n_i2;
        r_i1         <= n_i1;
        r_i0         <= n_i0;
        r_page       <= n_page;
        r_status     <= n_status;
        r_alloc_ok   <= n_alloc_ok;
        r_page_addr  <= n_page_addr;
        r_out_status <= n_out_status;
        r_free_cnt   <= n_free_cnt;
        r_used_cnt   <= n_used_cnt;
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.page_addr  = r_page_addr;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.free_count = r_free_cnt;
    assign o_rsp.used_count = r_used_cnt;

    // the summary levels must only ever point at words with a free page
    a_l1_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_L1) |-> (r_l1[r_i2] != '0))
        else $error("top summary points at an empty summary word");

    a_sum_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (sum_rdata != '0))
        else $error("summary word read empty during search");

    a_map_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP) |-> (map_rdata != '0))
        else $error("map word read empty during search");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP) |=> (r_used == $past(r_used)) ||
                               (r_used == $past(r_used) + COUNT_W'(1)))
        else $error("allocate moved the used count by more than one");

endmodule
`default_nettype wire
